// File: rtl/icfm_pkg.sv
`default_nettype none

package icfm_pkg;

  localparam int unsigned CounterBitsDefault = 16;
  localparam int unsigned StampWidth         = 16;
  localparam int unsigned OvfWidth           = 16;
  localparam int unsigned WordWidth          = 32;

  localparam logic [WordWidth-1:0] ClockHzReset = 32'd72000000;

  // Event kinds carried in tuser.
  localparam logic FuncCapture  = 1'b0;
  localparam logic FuncOverflow = 1'b1;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: rtl/icfm_div.sv
`default_nettype none

module icfm_div (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire  [icfm_pkg::WordWidth-1:0]    dividend_i,
  input  wire  [icfm_pkg::WordWidth-1:0]    divisor_i,
  output icfm_pkg::div_status_t             status_o,
  output logic [icfm_pkg::WordWidth-1:0]    quotient_o
);

  localparam int unsigned W  = icfm_pkg::WordWidth;
  localparam int unsigned CW = $clog2(W);

  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quot_q, quot_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [W:0] rem_shift;
  logic [W:0] diff;

  // One restoring step a cycle: shift in the next dividend bit, try to subtract.
  assign rem_shift = {rem_q[W-1:0], quot_q[W-1]};
  assign diff      = rem_shift - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (diff[W]) begin
        rem_d  = rem_shift;
        quot_d = {quot_q[W-2:0], 1'b0};
      end else begin
        rem_d  = diff;
        quot_d = {quot_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quot_q;

endmodule

`default_nettype wire

// File: rtl/input_capture_frequency_meter_unit.sv
`default_nettype none

// Reciprocal frequency meter fed by timer events.
// Input stream: tuser selects the event (0 capture edge, 1 timer overflow tick) and
// tdata carries the 16-bit counter value latched at a capture edge.
// Output stream: tdata[31:0] is the frequency in hertz, tdata[63:32] the period in ticks.
// cfg_we_i/cfg_wdata_i write the timer clock rate; write it only while the meter is idle.
// Overflow ticks and the first capture edge produce no word.
// The second capture edge computes the period and, when it is nonzero, runs a
// restoring divider that retires one quotient bit per cycle; the result then
// passes through the StOut state into the output register.
// The input is not ready during that time and reopens as the word appears.
// A zero period or a zero quotient rearms the meter without an output word.
// The output word sits in a register; a stalled receiver holds it, and the
// next capture can still be accepted. A following result waits until the
// register is free before the input is ready again.
// Reset returns the clock rate to 72 MHz and rearms for a first edge.
module input_capture_frequency_meter_unit #(
  parameter int unsigned COUNTER_BITS = icfm_pkg::CounterBitsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] capture_value
  input  wire  [0:0]  s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] frequency_hz, [63:32] period_ticks
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i
);

  localparam int unsigned W   = icfm_pkg::WordWidth;
  localparam int unsigned SW  = icfm_pkg::StampWidth;
  localparam int unsigned OW  = icfm_pkg::OvfWidth;
  localparam int unsigned SBW = (COUNTER_BITS < SW) ? COUNTER_BITS : SW;
  localparam int unsigned SPW = OW + 32;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [W-1:0]   clock_hz_q;
  logic           waiting_q, waiting_d;
  logic [SBW-1:0] first_q, first_d;
  logic [OW-1:0]  ovf_q, ovf_d;
  logic [W-1:0]   period_q, period_d;
  logic           out_valid_q, out_valid_d;
  logic [W-1:0]   out_freq_q, out_freq_d;
  logic [W-1:0]   out_period_q, out_period_d;

  logic                  in_fire;
  logic [SBW-1:0]        stamp;
  logic [SPW-1:0]        span_wide;
  logic [W-1:0]          period_w;
  logic                  div_start;
  icfm_pkg::div_status_t div_status;
  logic [W-1:0]          quotient;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign stamp   = s_axis_tdata[SBW-1:0];

  // Overflows weigh one full counter wrap each; anything beyond 32 bits drops out.
  assign span_wide = {{(SPW-OW){1'b0}}, ovf_q} << COUNTER_BITS;
  assign period_w  = span_wide[W-1:0] + W'(stamp) - W'(first_q);

  always_comb begin
    state_d      = state_q;
    waiting_d    = waiting_q;
    first_d      = first_q;
    ovf_d        = ovf_q;
    period_d     = period_q;
    out_valid_d  = out_valid_q;
    out_freq_d   = out_freq_q;
    out_period_d = out_period_q;
    div_start    = 1'b0;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser[0] == icfm_pkg::FuncOverflow) begin
            ovf_d = ovf_q + 1'b1;
          end else if (!waiting_q) begin
            first_d   = stamp;
            ovf_d     = '0;
            waiting_d = 1'b1;
          end else begin
            waiting_d = 1'b0;
            period_d  = period_w;
            if (period_w != '0) begin
              div_start = 1'b1;
              state_d   = StDiv;
            end
          end
        end
      end
      StDiv: begin
        if (div_status.done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (quotient == '0) begin
          state_d = StIdle;
        end else if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_freq_d   = quotient;
          out_period_d = period_q;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      clock_hz_q  <= icfm_pkg::ClockHzReset;
      waiting_q   <= 1'b0;
      first_q     <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      waiting_q   <= waiting_d;
      first_q     <= first_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        clock_hz_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    period_q     <= period_d;
    out_freq_q   <= out_freq_d;
    out_period_q <= out_period_d;
  end

  icfm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clock_hz_q),
    .divisor_i  (period_w),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_period_q, out_freq_q};

endmodule

`default_nettype wire

// File: rtl/icfm_checker.sv
`default_nettype none

module icfm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [63:0] m_axis_tdata
);

  // A stalled word stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A stalled word keeps its value.
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Only nonzero periods and quotients are ever reported.
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:0] != 32'd0) && (m_axis_tdata[63:32] != 32'd0))
    else $error("zero frequency or period reported");

  // A fresh word comes only out of a division, while the input is closed.
  a_word_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output word appeared without a division");

endmodule

bind input_capture_frequency_meter_unit icfm_checker u_icfm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/tb_input_capture_frequency_meter_unit.sv
`default_nettype none

module tb_input_capture_frequency_meter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CntBits     = icfm_pkg::CounterBitsDefault;
  localparam logic [63:0] StampMask   = (64'd1 << CntBits) - 64'd1;
  localparam int          DrainCycles = 48;
  localparam int          SpanTicks   = 24;

  typedef struct packed {
    logic [icfm_pkg::WordWidth-1:0] freq;
    logic [icfm_pkg::WordWidth-1:0] period;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [15:0] capture_value
  logic [0:0]  s_axis_tuser;    // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;    // [31:0] frequency_hz, [63:32] period_ticks
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  // Predicted meter state.
  logic [icfm_pkg::WordWidth-1:0]  clock_rate;
  logic                            meter_armed;
  logic [icfm_pkg::StampWidth-1:0] first_stamp;
  logic [icfm_pkg::OvfWidth-1:0]   overflow_ticks;

  reading_t pending_readings[$];
  int       mismatches;
  logic     burst;

  input_capture_frequency_meter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advances the meter by one event and queues the reading it produces, if any.
  task automatic compute_reading(input logic func, input logic [15:0] value);
    logic [63:0] stamp;
    logic [63:0] span;
    logic [31:0] period;
    reading_t    r;
    stamp = 64'(value) & StampMask;
    if (func == icfm_pkg::FuncOverflow) begin
      overflow_ticks = overflow_ticks + 1'b1;
    end else if (!meter_armed) begin
      first_stamp    = stamp[icfm_pkg::StampWidth-1:0];
      overflow_ticks = '0;
      meter_armed    = 1'b1;
    end else begin
      meter_armed = 1'b0;
      span        = 64'(overflow_ticks) << CntBits;
      period      = 32'(stamp + span - 64'(first_stamp));
      if (period != '0 && (clock_rate / period) != '0) begin
        r.freq   = clock_rate / period;
        r.period = period;
        pending_readings.push_back(r);
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  // tvalid stays high so that back-to-back words need no second assignment.
  task automatic send_event(input logic func, input logic [15:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    compute_reading(func, value);
    @(negedge clk_i);
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  // A zero period or quotient leaves no word behind, so the divider may still
  // be busy once the queue is empty; wait out its latency as well.
  task automatic settle_meter();
    stop_input();
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_clock_rate(input logic [31:0] rate);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    clock_rate = rate;
    @(negedge clk_i);
  endtask

  task automatic test_basic_measure();
    send_event(icfm_pkg::FuncOverflow, 16'hFFFF);
    send_event(icfm_pkg::FuncCapture, 16'd1000);
    send_event(icfm_pkg::FuncCapture, 16'd1072);
    send_event(icfm_pkg::FuncCapture, 16'h0000);
    send_event(icfm_pkg::FuncCapture, 16'hFFFF);
  endtask

  task automatic test_zero_period();
    send_event(icfm_pkg::FuncCapture, 16'h1234);
    send_event(icfm_pkg::FuncCapture, 16'h1234);
    send_event(icfm_pkg::FuncCapture, 16'hABCD);
    send_event(icfm_pkg::FuncCapture, 16'd77);
  endtask

  task automatic test_overflow_count();
    // Ticks ahead of the first edge must be cleared by it.
    send_event(icfm_pkg::FuncOverflow, 16'h5555);
    send_event(icfm_pkg::FuncOverflow, 16'hAAAA);
    send_event(icfm_pkg::FuncCapture, 16'd10);
    repeat (3) send_event(icfm_pkg::FuncOverflow, 16'h0000);
    send_event(icfm_pkg::FuncCapture, 16'd5);
    settle_meter();
  endtask

  // A long run of back-to-back ticks between the edges; the 16-bit tick count
  // only feeds the upper half of the period, so its wrap cannot change a reading.
  task automatic test_long_span();
    burst = 1'b1;
    send_event(icfm_pkg::FuncCapture, 16'd100);
    repeat (SpanTicks) send_event(icfm_pkg::FuncOverflow, 16'h0000);
    send_event(icfm_pkg::FuncCapture, 16'd300);
    burst = 1'b0;
    settle_meter();
  endtask

  task automatic test_clock_extremes();
    write_clock_rate(32'd1);
    send_event(icfm_pkg::FuncCapture, 16'd5);
    send_event(icfm_pkg::FuncCapture, 16'd6);
    send_event(icfm_pkg::FuncCapture, 16'd5);
    send_event(icfm_pkg::FuncCapture, 16'd7);
    settle_meter();
    write_clock_rate(32'hFFFF_FFFF);
    send_event(icfm_pkg::FuncCapture, 16'd0);
    send_event(icfm_pkg::FuncCapture, 16'd1);
    // Second stamp below the first with no ticks wraps the period.
    send_event(icfm_pkg::FuncCapture, 16'hFFFF);
    send_event(icfm_pkg::FuncCapture, 16'h0000);
    settle_meter();
  endtask

  task automatic test_random_traffic();
    logic [31:0] rates[5];
    int          budget[5];
    int          sent;
    int          ticks;
    logic [15:0] first;
    logic [15:0] second;
    rates[0] = icfm_pkg::ClockHzReset;
    rates[1] = $urandom | 32'd1;
    rates[2] = 32'hFFFF_FFFF;
    rates[3] = $urandom_range(2, 5000);
    rates[4] = 32'd1;
    budget   = '{300, 250, 250, 200, 150};
    for (int p = 0; p < 5; p++) begin
      settle_meter();
      write_clock_rate(rates[p]);
      sent = 0;
      while (sent < budget[p]) begin
        burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 6) == 0) begin
          send_event(1'($urandom_range(0, 1)), 16'($urandom));
          sent++;
        end else begin
          if (meter_armed) begin
            send_event(icfm_pkg::FuncCapture, 16'($urandom));
            sent++;
          end
          first = 16'($urandom);
          send_event(icfm_pkg::FuncCapture, first);
          sent++;
          if ($urandom_range(0, 9) < 4) begin
            // Short periods keep slow clock rates producing readings.
            ticks  = 0;
            second = first + 16'($urandom_range(0, 8));
          end else begin
            ticks  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40)
                                                 : $urandom_range(0, 3);
            second = 16'($urandom);
          end
          repeat (ticks) begin
            send_event(icfm_pkg::FuncOverflow, 16'($urandom));
            sent++;
          end
          send_event(icfm_pkg::FuncCapture, second);
          sent++;
        end
      end
    end
    burst = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_words
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata[31:0] !== want.freq) begin
          report_mismatch($sformatf("frequency_hz %0d, expected %0d",
                                    m_axis_tdata[31:0], want.freq));
        end
        if (m_axis_tdata[63:32] !== want.period) begin
          report_mismatch($sformatf("period_ticks %0d, expected %0d",
                                    m_axis_tdata[63:32], want.period));
        end
      end
    end
  end

  initial begin : receiver
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    burst          = 1'b0;
    mismatches     = 0;
    clock_rate     = icfm_pkg::ClockHzReset;
    meter_armed    = 1'b0;
    first_stamp    = '0;
    overflow_ticks = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_measure();
    test_zero_period();
    test_overflow_count();
    test_long_span();
    test_clock_extremes();
    test_random_traffic();
    settle_meter();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/icfm_pkg.sv
rtl/icfm_div.sv
rtl/input_capture_frequency_meter_unit.sv
rtl/icfm_checker.sv
tb/sv/tb_input_capture_frequency_meter_unit.sv
